FILE: hw/rtl/cau_pkg.sv
// Complex arithmetic unit: shared opcode type and per-request control word.
// No dependencies.
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Control that rides beside the data down the pipeline.
  typedef struct packed {
    op_t  op;
    logic neg_re;   // sign of the real divide numerator
    logic neg_im;   // sign of the imaginary divide numerator
    logic dz;       // divide with zero divisor
  } ctrl_t;

endpackage

FILE: hw/rtl/cau_front.sv
// Front end: product stage and sum/scale stage (two register stages).
// Depends on cau_pkg.
module cau_front #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     up_valid,
  output logic                                     up_ready,
  input  logic [1:0]                               op,
  input  logic signed [DATA_WIDTH-1:0]             ar,
  input  logic signed [DATA_WIDTH-1:0]             ai,
  input  logic signed [DATA_WIDTH-1:0]             br,
  input  logic signed [DATA_WIDTH-1:0]             bi,
  output logic                                     dn_valid,
  input  logic                                     dn_ready,
  output cau_pkg::ctrl_t                           dn_ctrl,
  output logic signed [2*DATA_WIDTH+1:0]           dn_val_re,
  output logic signed [2*DATA_WIDTH+1:0]           dn_val_im,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]          dn_num_re,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]          dn_num_im,
  output logic [2*DATA_WIDTH-1:0]                  dn_den
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int VW = 2 * W + 2;
  localparam int NW = 2 * W + FRAC_BITS + 1;

  // stage 1
  logic                 v1_r;
  op_t                  op1_r;
  logic signed [PW-1:0] p_arbr_r, p_aibi_r, p_arbi_r, p_aibr_r, p_brbr_r, p_bibi_r;
  logic signed [W:0]    s_re_r, s_im_r;
  logic signed [W:0]    s_re_nxt, s_im_nxt;

  // stage 2
  logic                 v2_r;
  ctrl_t                ctrl2_r, ctrl2_nxt;
  logic signed [VW-1:0] val_re_r, val_im_r, val_re_nxt, val_im_nxt;
  logic [NW-1:0]        num_re_r, num_im_r, num_re_nxt, num_im_nxt;
  logic [PW-1:0]        den_r, den_nxt;

  logic signed [VW-1:0] mre, mim, dre, dim;
  logic [VW-1:0]        dre_mag, dim_mag;
  logic                 rdy1, rdy2;

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    if (op_t'(op) == OP_SUB) begin
      s_re_nxt = (W+1)'(ar) - (W+1)'(br);
      s_im_nxt = (W+1)'(ai) - (W+1)'(bi);
    end else begin
      s_re_nxt = (W+1)'(ar) + (W+1)'(br);
      s_im_nxt = (W+1)'(ai) + (W+1)'(bi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      op1_r    <= op_t'(op);
      p_arbr_r <= PW'(ar) * PW'(br);
      p_aibi_r <= PW'(ai) * PW'(bi);
      p_arbi_r <= PW'(ar) * PW'(bi);
      p_aibr_r <= PW'(ai) * PW'(br);
      p_brbr_r <= PW'(br) * PW'(br);
      p_bibi_r <= PW'(bi) * PW'(bi);
      s_re_r   <= s_re_nxt;
      s_im_r   <= s_im_nxt;
    end
  end

  // multiply scaling is an arithmetic shift, i.e. floor
  always_comb begin
    mre     = (VW'(p_arbr_r) - VW'(p_aibi_r)) >>> FRAC_BITS;
    mim     = (VW'(p_arbi_r) + VW'(p_aibr_r)) >>> FRAC_BITS;
    dre     = VW'(p_arbr_r) + VW'(p_aibi_r);
    dim     = VW'(p_aibr_r) - VW'(p_arbi_r);
    dre_mag = dre[VW-1] ? VW'(-dre) : VW'(dre);
    dim_mag = dim[VW-1] ? VW'(-dim) : VW'(dim);
    den_nxt = PW'(p_brbr_r) + PW'(p_bibi_r);
    num_re_nxt = NW'(dre_mag) << FRAC_BITS;
    num_im_nxt = NW'(dim_mag) << FRAC_BITS;
    ctrl2_nxt.op     = op1_r;
    ctrl2_nxt.neg_re = dre[VW-1];
    ctrl2_nxt.neg_im = dim[VW-1];
    ctrl2_nxt.dz     = (op1_r == OP_DIV) && (den_nxt == '0);
    case (op1_r)
      OP_MUL: begin
        val_re_nxt = mre;
        val_im_nxt = mim;
      end
      OP_DIV: begin
        val_re_nxt = '0;
        val_im_nxt = '0;
      end
      default: begin
        val_re_nxt = VW'(s_re_r);
        val_im_nxt = VW'(s_im_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      ctrl2_r  <= ctrl2_nxt;
      val_re_r <= val_re_nxt;
      val_im_r <= val_im_nxt;
      num_re_r <= num_re_nxt;
      num_im_r <= num_im_nxt;
      den_r    <= den_nxt;
    end
  end

  assign dn_valid  = v2_r;
  assign dn_ctrl   = ctrl2_r;
  assign dn_val_re = val_re_r;
  assign dn_val_im = val_im_r;
  assign dn_num_re = num_re_r;
  assign dn_num_im = num_im_r;
  assign dn_den    = den_r;

endmodule

FILE: hw/rtl/cau_div.sv
// Pipelined restoring divider: one overflow stage, then one quotient bit per stage.
// Depends on cau_pkg.
module cau_div #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     up_valid,
  output logic                                     up_ready,
  input  cau_pkg::ctrl_t                           up_ctrl,
  input  logic signed [2*DATA_WIDTH+1:0]           up_val_re,
  input  logic signed [2*DATA_WIDTH+1:0]           up_val_im,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0]          up_num_re,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0]          up_num_im,
  input  logic [2*DATA_WIDTH-1:0]                  up_den,
  output logic                                     dn_valid,
  input  logic                                     dn_ready,
  output cau_pkg::ctrl_t                           dn_ctrl,
  output logic signed [2*DATA_WIDTH+1:0]           dn_val_re,
  output logic signed [2*DATA_WIDTH+1:0]           dn_val_im,
  output logic [DATA_WIDTH-1:0]                    dn_q_re,
  output logic [DATA_WIDTH-1:0]                    dn_q_im,
  output logic                                     dn_ovf_re,
  output logic                                     dn_ovf_im
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int QB = DATA_WIDTH;
  localparam int S  = QB + 1;
  localparam int PW = 2 * W;
  localparam int VW = 2 * W + 2;
  localparam int CW = 3 * W + FRAC_BITS + 1;

  logic                 v_r     [0:S-1];
  ctrl_t                ctrl_r  [0:S-1];
  logic signed [VW-1:0] vre_r   [0:S-1];
  logic signed [VW-1:0] vim_r   [0:S-1];
  logic [CW-1:0]        rre_r   [0:S-1];
  logic [CW-1:0]        rim_r   [0:S-1];
  logic [PW-1:0]        d_r     [0:S-1];
  logic [W-1:0]         qre_r   [0:S-1];
  logic [W-1:0]         qim_r   [0:S-1];
  logic                 ore_r   [0:S-1];
  logic                 oim_r   [0:S-1];

  logic                 v_in    [0:S-1];
  ctrl_t                ctrl_in [0:S-1];
  logic signed [VW-1:0] vre_in  [0:S-1];
  logic signed [VW-1:0] vim_in  [0:S-1];
  logic [CW-1:0]        rre_in  [0:S-1];
  logic [CW-1:0]        rim_in  [0:S-1];
  logic [PW-1:0]        d_in    [0:S-1];
  logic [W-1:0]         qre_in  [0:S-1];
  logic [W-1:0]         qim_in  [0:S-1];
  logic                 ore_in  [0:S-1];
  logic                 oim_in  [0:S-1];

  logic [S:0]           rdy;

  assign rdy[S]   = dn_ready;
  assign up_ready = rdy[0];

  // stage 0 is fed from the ports, the rest from the stage before
  assign v_in[0]    = up_valid;
  assign ctrl_in[0] = up_ctrl;
  assign vre_in[0]  = up_val_re;
  assign vim_in[0]  = up_val_im;
  assign rre_in[0]  = CW'(up_num_re);
  assign rim_in[0]  = CW'(up_num_im);
  assign d_in[0]    = up_den;
  assign qre_in[0]  = '0;
  assign qim_in[0]  = '0;
  assign ore_in[0]  = 1'b0;
  assign oim_in[0]  = 1'b0;

  for (genvar k = 1; k < S; k++) begin : g_link
    assign v_in[k]    = v_r[k-1];
    assign ctrl_in[k] = ctrl_r[k-1];
    assign vre_in[k]  = vre_r[k-1];
    assign vim_in[k]  = vim_r[k-1];
    assign rre_in[k]  = rre_r[k-1];
    assign rim_in[k]  = rim_r[k-1];
    assign d_in[k]    = d_r[k-1];
    assign qre_in[k]  = qre_r[k-1];
    assign qim_in[k]  = qim_r[k-1];
    assign ore_in[k]  = ore_r[k-1];
    assign oim_in[k]  = oim_r[k-1];
  end

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [CW-1:0] rre_nxt, rim_nxt, dsh;
    logic [W-1:0]  qre_nxt, qim_nxt;
    logic          ore_nxt, oim_nxt;

    assign rdy[k] = !v_r[k] || rdy[k+1];

    if (k == 0) begin : g_ovf
      // quotient would need more than QB bits
      assign dsh     = CW'(d_in[k]) << QB;
      assign ore_nxt = rre_in[k] >= dsh;
      assign oim_nxt = rim_in[k] >= dsh;
      assign rre_nxt = rre_in[k];
      assign rim_nxt = rim_in[k];
      assign qre_nxt = qre_in[k];
      assign qim_nxt = qim_in[k];
    end else begin : g_bit
      localparam int I = QB - k;
      assign dsh     = CW'(d_in[k]) << I;
      assign ore_nxt = ore_in[k];
      assign oim_nxt = oim_in[k];
      always_comb begin
        rre_nxt = rre_in[k];
        rim_nxt = rim_in[k];
        qre_nxt = qre_in[k];
        qim_nxt = qim_in[k];
        if (rre_in[k] >= dsh) begin
          rre_nxt = rre_in[k] - dsh;
          qre_nxt = qre_in[k] | (W'(1) << I);
        end
        if (rim_in[k] >= dsh) begin
          rim_nxt = rim_in[k] - dsh;
          qim_nxt = qim_in[k] | (W'(1) << I);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in[k]) begin
        ctrl_r[k] <= ctrl_in[k];
        vre_r[k]  <= vre_in[k];
        vim_r[k]  <= vim_in[k];
        rre_r[k]  <= rre_nxt;
        rim_r[k]  <= rim_nxt;
        d_r[k]    <= d_in[k];
        qre_r[k]  <= qre_nxt;
        qim_r[k]  <= qim_nxt;
        ore_r[k]  <= ore_nxt;
        oim_r[k]  <= oim_nxt;
      end
    end
  end

  assign dn_valid  = v_r[S-1];
  assign dn_ctrl   = ctrl_r[S-1];
  assign dn_val_re = vre_r[S-1];
  assign dn_val_im = vim_r[S-1];
  assign dn_q_re   = qre_r[S-1];
  assign dn_q_im   = qim_r[S-1];
  assign dn_ovf_re = ore_r[S-1];
  assign dn_ovf_im = oim_r[S-1];

endmodule

FILE: hw/rtl/cau_sat.sv
// Result select, sign restore and saturation, into the output register.
// Depends on cau_pkg.
module cau_sat #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  cau_pkg::ctrl_t                   up_ctrl,
  input  logic signed [2*DATA_WIDTH+1:0]   up_val_re,
  input  logic signed [2*DATA_WIDTH+1:0]   up_val_im,
  input  logic [DATA_WIDTH-1:0]            up_q_re,
  input  logic [DATA_WIDTH-1:0]            up_q_im,
  input  logic                             up_ovf_re,
  input  logic                             up_ovf_im,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [DATA_WIDTH-1:0]     out_re,
  output logic signed [DATA_WIDTH-1:0]     out_im,
  output logic                             out_sat,
  output logic                             out_dz
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int VW = 2 * W + 2;
  localparam logic [W-1:0]         HALF  = W'(1) << (W - 1);
  localparam logic [W-1:0]         MAXU  = HALF - W'(1);
  localparam logic signed [VW-1:0] VMAX  = VW'(MAXU);
  localparam logic signed [VW-1:0] VMIN  = -VMAX - VW'(1);

  logic                valid_r;
  logic signed [W-1:0] re_r, im_r, re_nxt, im_nxt;
  logic                sat_r, dz_r, sat_nxt, dz_nxt;
  logic                sre, sim;

  assign up_ready = !valid_r || !out_stall;

  always_comb begin
    sre    = 1'b0;
    sim    = 1'b0;
    re_nxt = '0;
    im_nxt = '0;
    dz_nxt = 1'b0;
    if (up_ctrl.op == OP_DIV) begin
      if (up_ctrl.dz) begin
        dz_nxt = 1'b1;
      end else begin
        sre = up_ovf_re || (up_q_re > (up_ctrl.neg_re ? HALF : MAXU));
        sim = up_ovf_im || (up_q_im > (up_ctrl.neg_im ? HALF : MAXU));
        if (sre) begin
          re_nxt = up_ctrl.neg_re ? HALF : MAXU;
        end else begin
          re_nxt = up_ctrl.neg_re ? -up_q_re : up_q_re;
        end
        if (sim) begin
          im_nxt = up_ctrl.neg_im ? HALF : MAXU;
        end else begin
          im_nxt = up_ctrl.neg_im ? -up_q_im : up_q_im;
        end
      end
    end else begin
      sre = (up_val_re > VMAX) || (up_val_re < VMIN);
      sim = (up_val_im > VMAX) || (up_val_im < VMIN);
      if (up_val_re > VMAX) begin
        re_nxt = MAXU;
      end else if (up_val_re < VMIN) begin
        re_nxt = HALF;
      end else begin
        re_nxt = up_val_re[W-1:0];
      end
      if (up_val_im > VMAX) begin
        im_nxt = MAXU;
      end else if (up_val_im < VMIN) begin
        im_nxt = HALF;
      end else begin
        im_nxt = up_val_im[W-1:0];
      end
    end
    sat_nxt = sre || sim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      sat_r <= sat_nxt;
      dz_r  <= dz_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_re    = re_r;
  assign out_im    = im_r;
  assign out_sat   = sat_r;
  assign out_dz    = dz_r;

endmodule

FILE: hw/rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: front end, pipelined divider, saturation stage.
// Depends on cau_pkg, cau_front, cau_div and cau_sat.
//
// Takes one request per cycle while in_stall is low: an opcode (add, subtract,
// multiply, divide) and two complex operands in signed fixed point (DATA_WIDTH
// bits, FRAC_BITS fractional), and returns one complex result per request, in
// order. Every opcode runs through the same pipeline: two front stages form the
// products and sums, the divider takes one overflow stage plus one stage per
// quotient bit, and one output register follows. The divider's bit-per-stage chain
// sets the pipeline depth; throughput is one request per clock while the output is
// not stalled. Multiply results are floored after scaling, divide quotients truncate
// toward zero, and each part saturates with the saturated flag set. A divide by
// zero returns zero with divide_by_zero set. Both channels use valid/stall; a
// stalled output stage holds its request while upstream stages still fill any
// empty slots (bubbles collapse).
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic signed [DATA_WIDTH-1:0]  in_a_real,
  input  logic signed [DATA_WIDTH-1:0]  in_a_imag,
  input  logic signed [DATA_WIDTH-1:0]  in_b_real,
  input  logic signed [DATA_WIDTH-1:0]  in_b_imag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_r_real,
  output logic signed [DATA_WIDTH-1:0]  out_r_imag,
  output logic                          out_saturated,
  output logic                          out_divide_by_zero
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int VW = 2 * W + 2;
  localparam int NW = 2 * W + FRAC_BITS + 1;
  localparam logic signed [W-1:0] RMAX = W'((W'(1) << (W - 1)) - W'(1));
  localparam logic signed [W-1:0] RMIN = ~RMAX;

  // front end -> divider
  logic                 f_valid, f_ready;
  ctrl_t                f_ctrl;
  logic signed [VW-1:0] f_val_re, f_val_im;
  logic [NW-1:0]        f_num_re, f_num_im;
  logic [2*W-1:0]       f_den;

  // divider -> saturation
  logic                 d_valid, d_ready;
  ctrl_t                d_ctrl;
  logic signed [VW-1:0] d_val_re, d_val_im;
  logic [W-1:0]         d_q_re, d_q_im;
  logic                 d_ovf_re, d_ovf_im;

  logic                 in_ready;

  assign in_stall = !in_ready;

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .op       (in_opcode),
    .ar       (in_a_real),
    .ai       (in_a_imag),
    .br       (in_b_real),
    .bi       (in_b_imag),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_ctrl  (f_ctrl),
    .dn_val_re(f_val_re),
    .dn_val_im(f_val_im),
    .dn_num_re(f_num_re),
    .dn_num_im(f_num_im),
    .dn_den   (f_den)
  );

  cau_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_ctrl  (f_ctrl),
    .up_val_re(f_val_re),
    .up_val_im(f_val_im),
    .up_num_re(f_num_re),
    .up_num_im(f_num_im),
    .up_den   (f_den),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_ctrl  (d_ctrl),
    .dn_val_re(d_val_re),
    .dn_val_im(d_val_im),
    .dn_q_re  (d_q_re),
    .dn_q_im  (d_q_im),
    .dn_ovf_re(d_ovf_re),
    .dn_ovf_im(d_ovf_im)
  );

  cau_sat #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d_valid),
    .up_ready (d_ready),
    .up_ctrl  (d_ctrl),
    .up_val_re(d_val_re),
    .up_val_im(d_val_im),
    .up_q_re  (d_q_re),
    .up_q_im  (d_q_im),
    .up_ovf_re(d_ovf_re),
    .up_ovf_im(d_ovf_im),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_re   (out_r_real),
    .out_im   (out_r_imag),
    .out_sat  (out_saturated),
    .out_dz   (out_divide_by_zero)
  );

  // divide by zero always yields a clean zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |->
      out_r_real == '0 && out_r_imag == '0 && !out_saturated)
    else $error("divide-by-zero request with non-zero result");

  // a saturated request has at least one part pinned to a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_r_real == RMAX || out_r_real == RMIN ||
      out_r_imag == RMAX || out_r_imag == RMIN)
    else $error("saturated flag without a clamped part");

  // the output stage must hold a waiting request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_r_real) && $stable(out_r_imag))
    else $error("stalled request lost or changed");

  // the saturation stage never refuses a request while its output register is empty
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !d_valid || d_ready)
    else $error("saturation stage refused request with empty output");

endmodule

FILE: bench/cau_result_checker.sv
// Result checker for the complex arithmetic unit: watches both channels, predicts
// each result from the accepted request and compares in order. Depends on cau_pkg.
`timescale 1ns / 100ps

module cau_result_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_a_real,
  input  logic signed [DATA_WIDTH-1:0] in_a_imag,
  input  logic signed [DATA_WIDTH-1:0] in_b_real,
  input  logic signed [DATA_WIDTH-1:0] in_b_imag,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [DATA_WIDTH-1:0] out_r_real,
  input  logic signed [DATA_WIDTH-1:0] out_r_imag,
  input  logic                         out_saturated,
  input  logic                         out_divide_by_zero,
  output int                           fail_count,
  output int                           pending
);
  import cau_pkg::*;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic                         sat;
    logic                         dz;
  } cplx_result_t;

  cplx_result_t result_fifo[$];

  localparam longint PMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint PMIN = -PMAX - 1;

  function automatic longint floor_scale(longint v);
    return v >>> FRAC_BITS;
  endfunction

  // Quotient toward zero.
  function automatic longint quot_trunc(longint n, longint d);
    longint m;
    m = (n < 0) ? -n : n;
    m = m / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] clip(longint v, ref logic sat);
    if (v > PMAX) begin
      sat = 1'b1;
      return PMAX[DATA_WIDTH-1:0];
    end
    if (v < PMIN) begin
      sat = 1'b1;
      return PMIN[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic cplx_result_t predict_complex(op_t op, longint ar, longint ai,
                                                   longint br, longint bi);
    cplx_result_t r;
    longint re, im, den;
    logic sat;
    re = 0;
    im = 0;
    sat = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = floor_scale(ar * br - ai * bi);
        im = floor_scale(ar * bi + ai * br);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = quot_trunc((ar * br + ai * bi) * (64'sd1 <<< FRAC_BITS), den);
          im = quot_trunc((br * ai - bi * ar) * (64'sd1 <<< FRAC_BITS), den);
        end
      end
    endcase
    r.re = clip(re, sat);
    r.im = clip(im, sat);
    r.sat = sat;
    return r;
  endfunction

  initial fail_count = 0;
  assign pending = result_fifo.size();

  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (rst_n && in_valid && !in_stall)
      result_fifo.push_back(predict_complex(op_t'(in_opcode), in_a_real, in_a_imag,
                                            in_b_real, in_b_imag));
    if (rst_n && out_valid && !out_stall) begin
      if (result_fifo.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result re=%0d im=%0d",
                                       out_r_real, out_r_imag);
      end else begin
        exp_r = result_fifo.pop_front();
        if (out_r_real !== exp_r.re || out_r_imag !== exp_r.im ||
            out_saturated !== exp_r.sat || out_divide_by_zero !== exp_r.dz) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp re=%0d im=%0d sat=%b dz=%b got re=%0d im=%0d sat=%b dz=%b",
                     exp_r.re, exp_r.im, exp_r.sat, exp_r.dz, out_r_real, out_r_imag,
                     out_saturated, out_divide_by_zero);
        end
      end
    end
  end
endmodule

FILE: bench/tb_complex_arithmetic_unit.sv
// Testbench top for the complex arithmetic unit: drives requests and the result stall,
// gives the verdict. Depends on cau_pkg, complex_arithmetic_unit, cau_result_checker.
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int LATENCY = DW + 4;
  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM = 930;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic signed [DW-1:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_r_real, out_r_imag;
  logic out_saturated, out_divide_by_zero;
  int fail_count, pending;

  // Receiver modes: idle bursts on, a long hold-off, and a quiet tail.
  bit long_hold = 1'b0;
  bit quiet = 1'b0;

  always #1 clk = ~clk;

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(8)) u_top (.*);

  cau_result_checker #(.DATA_WIDTH(DW), .FRAC_BITS(8)) u_chk (.*);

  // Directed operands: extremes, zero divisor, flooring/truncation signs.
  logic signed [DW-1:0] dir_vals [8] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                                         16'sh0100, 16'shff00, 16'sh0001, 16'sh0180};

  function automatic logic signed [DW-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return dir_vals[$urandom_range(0, 7)];
      1: return $signed(16'($urandom_range(0, 1023))) - 16'sd512; // small, near unity
      default: return 16'($urandom());
    endcase
  endfunction

  // One request, held until accepted. An occasional idle gap first, driven at the falling edge.
  task automatic send_request(op_t op, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
                              logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Result-side stall: random bursts, a long hold-off when asked, none at the end.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every opcode over extreme operands, plus a zero divisor and an all-minimum multiply.
    for (k = 0; k < N_DIRECTED - 2; k++)
      send_request(op_t'(k % 4), dir_vals[k % 8], dir_vals[(k + 3) % 8],
                   dir_vals[(k + 5) % 8], dir_vals[(k / 4 + 1) % 8]);
    send_request(OP_DIV, 16'sh1234, -16'sh0567, '0, '0);
    send_request(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

    // Sender pauses until the pipeline has drained.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 200) long_hold = 1'b1;  // block fills and stalls its input
      if (k == N_RANDOM - 150) quiet = 1'b1;
      if ($urandom_range(0, 15) == 0)
        send_request(OP_DIV, rand_part(), rand_part(), '0, '0);
      else
        send_request(op_t'($urandom_range(0, 3)), rand_part(), rand_part(),
                     rand_part(), rand_part());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0) $display("complex_arithmetic_unit verification clean");
    else $display("complex_arithmetic_unit verification failed");
    $finish;
  end

  initial begin
    #200000;
    $display("complex_arithmetic_unit verification failed");
    $finish;
  end
endmodule
